@@ hdl/text_line_number_and_caret_filter_top_assert.svh @@
// Assertion macros shared by the line number and caret filter modules.
`ifndef TEXT_LINE_NUMBER_AND_CARET_FILTER_TOP_ASSERT_SVH
`define TEXT_LINE_NUMBER_AND_CARET_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clock and held off during reset.
`define TLNCF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and held off during reset.
`define TLNCF_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/tlncf_pkg.sv @@
// Types, constants and the control store of the line number and caret filter.
package tlncf_pkg;

   localparam int PC_W       = 5;
   localparam int PAD_WIDTH  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUMBER_MODE   = 3'd0,
      CSR_SQUEEZE_BLANK = 3'd1,
      CSR_END_MARK      = 3'd2,
      CSR_TAB_CARET     = 3'd3,
      CSR_CTL_CARET     = 3'd4
   } csr_index_type;

   localparam logic [1:0] NUM_EVERY    = 2'd1;
   localparam logic [1:0] NUM_NONBLANK = 2'd2;

   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NL        = 8'h0a;
   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_CARET     = 8'h5e;
   localparam logic [7:0] CH_I         = 8'h49;
   localparam logic [7:0] CH_QMARK     = 8'h3f;
   localparam logic [7:0] CH_M         = 8'h4d;
   localparam logic [7:0] CH_DASH      = 8'h2d;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_DEL       = 8'h7f;
   localparam logic [7:0] CTL_LIMIT    = 8'h20;
   localparam logic [7:0] CARET_OFFSET = 8'h40;

   typedef enum logic [3:0] {
      SRC_NONE, SRC_PREFIX, SRC_TAB, SRC_DOLLAR, SRC_NL, SRC_CARET, SRC_I,
      SRC_PLUS64, SRC_QMARK, SRC_M, SRC_DASH, SRC_LOW, SRC_RAW
   } src_type;

   typedef enum logic [3:0] {
      C_NEVER, C_ALWAYS, C_SQUEEZE, C_NO_NUM, C_POS_NZ, C_NOT_NL, C_NO_ENDS,
      C_NOT_TABSH, C_IS_CTL, C_IS_DEL, C_NOT_HIGH, C_LOW_PLAIN, C_LOW_DEL
   } cond_type;

   typedef enum logic [2:0] {
      ACT_NONE, ACT_LOAD, ACT_POS_INIT, ACT_POS_DEC, ACT_COUNT, ACT_END_NL, ACT_END_CH
   } act_type;

   typedef logic [PC_W-1:0] pc_type;

   typedef struct packed {
      logic     take;
      logic     emit;
      src_type  src;
      logic     last;
      cond_type cond;
      pc_type   target;
      act_type  act;
   } ucode_type;

   typedef struct packed {
      ucode_type word;
      logic      exec;
   } ctrl_type;

   typedef struct packed {
      logic squeeze;
      logic no_num;
      logic pos_nz;
      logic not_nl;
      logic no_ends;
      logic not_tabsh;
      logic is_ctl;
      logic is_del;
      logic not_high;
      logic low_plain;
      logic low_del;
   } status_type;

   typedef struct packed {
      logic [1:0] number_mode;
      logic       squeeze_blank;
      logic       end_mark;
      logic       tab_caret;
      logic       ctl_caret;
   } cfg_type;

   localparam pc_type ST_IDLE      = 5'd0;
   localparam pc_type ST_SQUEEZE   = 5'd1;
   localparam pc_type ST_NUM       = 5'd2;
   localparam pc_type ST_DIGIT     = 5'd3;
   localparam pc_type ST_TAB       = 5'd4;
   localparam pc_type ST_NEWLINE   = 5'd5;
   localparam pc_type ST_ENDS      = 5'd6;
   localparam pc_type ST_DOLLAR    = 5'd7;
   localparam pc_type ST_NL        = 5'd8;
   localparam pc_type ST_TABS      = 5'd9;
   localparam pc_type ST_TAB_CARET = 5'd10;
   localparam pc_type ST_TAB_I     = 5'd11;
   localparam pc_type ST_CTL       = 5'd12;
   localparam pc_type ST_DEL       = 5'd13;
   localparam pc_type ST_HIGH      = 5'd14;
   localparam pc_type ST_M         = 5'd15;
   localparam pc_type ST_DASH      = 5'd16;
   localparam pc_type ST_CARET     = 5'd17;
   localparam pc_type ST_PLUS64    = 5'd18;
   localparam pc_type ST_QMARK     = 5'd19;
   localparam pc_type ST_LOW       = 5'd20;
   localparam pc_type ST_RAW       = 5'd21;
   localparam pc_type ST_LAST      = ST_RAW;

   function automatic ucode_type uword(input logic take, input logic emit, input src_type src,
                                       input logic last, input cond_type cond,
                                       input pc_type target, input act_type act);
      ucode_type w;
      w.take   = take;
      w.emit   = emit;
      w.src    = src;
      w.last   = last;
      w.cond   = cond;
      w.target = target;
      w.act    = act;
      return w;
   endfunction

   // A step whose condition holds jumps to its target, otherwise it falls through.
   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      case (pc)
         ST_IDLE:      w = uword(1'b1, 1'b0, SRC_NONE,   1'b0, C_NEVER,     ST_IDLE,    ACT_LOAD);
         ST_SQUEEZE:   w = uword(1'b0, 1'b0, SRC_NONE,   1'b0, C_SQUEEZE,   ST_IDLE,    ACT_NONE);
         ST_NUM:       w = uword(1'b0, 1'b0, SRC_NONE,   1'b0, C_NO_NUM,    ST_NEWLINE,
                                 ACT_POS_INIT);
         ST_DIGIT:     w = uword(1'b0, 1'b1, SRC_PREFIX, 1'b0, C_POS_NZ,    ST_DIGIT,
                                 ACT_POS_DEC);
         ST_TAB:       w = uword(1'b0, 1'b1, SRC_TAB,    1'b0, C_NEVER,     ST_IDLE,    ACT_COUNT);
         ST_NEWLINE:   w = uword(1'b0, 1'b0, SRC_NONE,   1'b0, C_NOT_NL,    ST_TABS,    ACT_NONE);
         ST_ENDS:      w = uword(1'b0, 1'b0, SRC_NONE,   1'b0, C_NO_ENDS,   ST_NL,      ACT_NONE);
         ST_DOLLAR:    w = uword(1'b0, 1'b1, SRC_DOLLAR, 1'b0, C_NEVER,     ST_IDLE,    ACT_NONE);
         ST_NL:        w = uword(1'b0, 1'b1, SRC_NL,     1'b1, C_ALWAYS,    ST_IDLE,
                                 ACT_END_NL);
         ST_TABS:      w = uword(1'b0, 1'b0, SRC_NONE,   1'b0, C_NOT_TABSH, ST_CTL,     ACT_NONE);
         ST_TAB_CARET: w = uword(1'b0, 1'b1, SRC_CARET,  1'b0, C_NEVER,     ST_IDLE,    ACT_NONE);
         ST_TAB_I:     w = uword(1'b0, 1'b1, SRC_I,      1'b1, C_ALWAYS,    ST_IDLE,
                                 ACT_END_CH);
         ST_CTL:       w = uword(1'b0, 1'b0, SRC_NONE,   1'b0, C_IS_CTL,    ST_CARET,   ACT_NONE);
         ST_DEL:       w = uword(1'b0, 1'b0, SRC_NONE,   1'b0, C_IS_DEL,    ST_CARET,   ACT_NONE);
         ST_HIGH:      w = uword(1'b0, 1'b0, SRC_NONE,   1'b0, C_NOT_HIGH,  ST_RAW,     ACT_NONE);
         ST_M:         w = uword(1'b0, 1'b1, SRC_M,      1'b0, C_NEVER,     ST_IDLE,    ACT_NONE);
         ST_DASH:      w = uword(1'b0, 1'b1, SRC_DASH,   1'b0, C_LOW_PLAIN, ST_LOW,     ACT_NONE);
         ST_CARET:     w = uword(1'b0, 1'b1, SRC_CARET,  1'b0, C_LOW_DEL,   ST_QMARK,   ACT_NONE);
         ST_PLUS64:    w = uword(1'b0, 1'b1, SRC_PLUS64, 1'b1, C_ALWAYS,    ST_IDLE,
                                 ACT_END_CH);
         ST_QMARK:     w = uword(1'b0, 1'b1, SRC_QMARK,  1'b1, C_ALWAYS,    ST_IDLE,
                                 ACT_END_CH);
         ST_LOW:       w = uword(1'b0, 1'b1, SRC_LOW,    1'b1, C_ALWAYS,    ST_IDLE,
                                 ACT_END_CH);
         ST_RAW:       w = uword(1'b0, 1'b1, SRC_RAW,    1'b1, C_ALWAYS,    ST_IDLE,
                                 ACT_END_CH);
         default:      w = uword(1'b0, 1'b0, SRC_NONE,   1'b0, C_ALWAYS,    ST_IDLE,    ACT_NONE);
      endcase
      return w;
   endfunction

endpackage

@@ hdl/tlncf_sequencer.sv @@
// Step counter, control store lookup and branch logic of the filter.
`include "text_line_number_and_caret_filter_top_assert.svh"

module tlncf_sequencer
   import tlncf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   input  logic       req_valid,
   input  logic       out_free,
   output ctrl_type   ctrl
);

   pc_type    pc_ff;
   pc_type    pc_in;
   ucode_type word;
   logic      exec;
   logic      hit;

   assign word = ucode_rom(pc_ff);

   // A step waits for an input byte or for room in the output register.
   assign exec = (!word.take || req_valid) && (!word.emit || out_free);

   always_comb begin
      case (word.cond)
         C_NEVER:     hit = 1'b0;
         C_ALWAYS:    hit = 1'b1;
         C_SQUEEZE:   hit = status.squeeze;
         C_NO_NUM:    hit = status.no_num;
         C_POS_NZ:    hit = status.pos_nz;
         C_NOT_NL:    hit = status.not_nl;
         C_NO_ENDS:   hit = status.no_ends;
         C_NOT_TABSH: hit = status.not_tabsh;
         C_IS_CTL:    hit = status.is_ctl;
         C_IS_DEL:    hit = status.is_del;
         C_NOT_HIGH:  hit = status.not_high;
         C_LOW_PLAIN: hit = status.low_plain;
         C_LOW_DEL:   hit = status.low_del;
         default:     hit = 1'b0;
      endcase
   end

   always_comb begin
      pc_in = pc_ff;
      if (exec) begin
         pc_in = hit ? word.target : pc_ff + pc_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.word = word;
   assign ctrl.exec = exec;

   `TLNCF_ASSERT_IMP(a_pc_in_program, 1'b1, pc_ff <= ST_LAST, "step counter left the program")

endmodule

@@ hdl/tlncf_datapath.sv @@
// Byte latch, decimal line counter, prefix position and output byte selection.
`include "text_line_number_and_caret_filter_top_assert.svh"

module tlncf_datapath
   import tlncf_pkg::*;
#(
   parameter int LINE_DIGITS = 10
)(
   input  logic       clock,
   input  logic       reset,
   input  ctrl_type   ctrl,
   input  logic [7:0] req_in_byte,
   input  cfg_type    cfg,
   output status_type status,
   output logic [7:0] emit_byte
);

   localparam int NDW = $clog2(LINE_DIGITS + 1);
   localparam int PW  = $clog2(LINE_DIGITS);

   logic [7:0]             byte_ff;
   logic                   line_head_ff;
   logic                   prev_blank_ff;
   logic [3:0]             dig_ff [LINE_DIGITS];
   logic [3:0]             dig_in [LINE_DIGITS];
   logic [PW-1:0]          pos_ff;
   logic [PW-1:0]          pos_in;
   logic [NDW-1:0]         nd;
   logic [LINE_DIGITS-1:0] nine;
   logic                   all_nine;
   logic                   blank;
   logic                   do_num;
   logic                   step_act;
   logic [6:0]             low;

   assign step_act = ctrl.exec;
   assign low      = byte_ff[6:0];
   assign blank    = line_head_ff && (byte_ff == CH_NL);
   assign do_num   = line_head_ff &&
                     ((cfg.number_mode == NUM_EVERY) ||
                      ((cfg.number_mode == NUM_NONBLANK) && !blank));

   assign status.squeeze   = blank && cfg.squeeze_blank && prev_blank_ff;
   assign status.no_num    = !do_num;
   assign status.pos_nz    = (pos_ff != '0);
   assign status.not_nl    = (byte_ff != CH_NL);
   assign status.no_ends   = !cfg.end_mark;
   assign status.not_tabsh = !((byte_ff == CH_TAB) && cfg.tab_caret);
   assign status.is_ctl    = cfg.ctl_caret && (byte_ff < CTL_LIMIT) &&
                             (byte_ff != CH_NL) && (byte_ff != CH_TAB);
   assign status.is_del    = cfg.ctl_caret && (byte_ff == CH_DEL);
   assign status.not_high  = !(cfg.ctl_caret && byte_ff[7]);
   assign status.low_plain = (low >= CTL_LIMIT[6:0]) && (low != CH_DEL[6:0]);
   assign status.low_del   = (low == CH_DEL[6:0]);

   // Number of significant digits in the counter, at least one.
   always_comb begin
      nd = NDW'(1);
      for (int i = 0; i < LINE_DIGITS; i++) begin
         if (dig_ff[i] != 4'd0) begin
            nd = NDW'(i + 1);
         end
      end
   end

   // The counter is kept in decimal digits; a digit steps when all lower ones are nine.
   always_comb begin
      logic [LINE_DIGITS-1:0] lower;
      logic                   inc;
      for (int i = 0; i < LINE_DIGITS; i++) begin
         nine[i] = (dig_ff[i] == 4'd9);
      end
      all_nine = &nine;
      for (int i = 0; i < LINE_DIGITS; i++) begin
         lower     = {LINE_DIGITS{1'b1}} >> (LINE_DIGITS - i);
         inc       = &(nine | ~lower);
         dig_in[i] = dig_ff[i];
         if (step_act && (ctrl.word.act == ACT_COUNT) && !all_nine && inc) begin
            dig_in[i] = nine[i] ? 4'd0 : dig_ff[i] + 4'd1;
         end
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (step_act && (ctrl.word.act == ACT_POS_INIT)) begin
         pos_in = (nd > NDW'(PAD_WIDTH)) ? PW'(nd - NDW'(1)) : PW'(PAD_WIDTH - 1);
      end else if (step_act && (ctrl.word.act == ACT_POS_DEC) && status.pos_nz) begin
         pos_in = pos_ff - PW'(1);
      end
   end

   always_comb begin
      case (ctrl.word.src)
         SRC_PREFIX: begin
            if (NDW'(pos_ff) >= nd) begin
               emit_byte = CH_SPACE;
            end else begin
               emit_byte = CH_ZERO + {4'b0000, dig_ff[pos_ff]};
            end
         end
         SRC_TAB:    emit_byte = CH_TAB;
         SRC_DOLLAR: emit_byte = CH_DOLLAR;
         SRC_NL:     emit_byte = CH_NL;
         SRC_CARET:  emit_byte = CH_CARET;
         SRC_I:      emit_byte = CH_I;
         SRC_PLUS64: emit_byte = {1'b0, low} + CARET_OFFSET;
         SRC_QMARK:  emit_byte = CH_QMARK;
         SRC_M:      emit_byte = CH_M;
         SRC_DASH:   emit_byte = CH_DASH;
         SRC_LOW:    emit_byte = {1'b0, low};
         SRC_RAW:    emit_byte = byte_ff;
         default:    emit_byte = byte_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (step_act && (ctrl.word.act == ACT_LOAD)) begin
         byte_ff <= req_in_byte;
      end
      pos_ff <= pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_head_ff  <= 1'b1;
         prev_blank_ff <= 1'b0;
         for (int i = 0; i < LINE_DIGITS; i++) begin
            dig_ff[i] <= (i == 0) ? 4'd1 : 4'd0;
         end
      end else begin
         for (int i = 0; i < LINE_DIGITS; i++) begin
            dig_ff[i] <= dig_in[i];
         end
         if (step_act && (ctrl.word.act == ACT_END_NL)) begin
            line_head_ff  <= 1'b1;
            prev_blank_ff <= blank;
         end else if (step_act && (ctrl.word.act == ACT_END_CH)) begin
            line_head_ff  <= 1'b0;
            prev_blank_ff <= 1'b0;
         end
      end
   end

   `TLNCF_ASSERT_NXT(a_load_keeps_line_state, step_act && (ctrl.word.act == ACT_LOAD), $stable(line_head_ff) && $stable(prev_blank_ff), "byte load changed line state")
   `TLNCF_ASSERT_IMP(a_count_at_line_start, step_act && (ctrl.word.act == ACT_COUNT), line_head_ff, "line counter stepped away from a line start")
   `TLNCF_ASSERT_IMP(a_low_digit_decimal, 1'b1, dig_ff[0] <= 4'd9, "low counter digit is not decimal")

endmodule

@@ hdl/text_line_number_and_caret_filter_top.sv @@
// Top level of the line number and caret notation text filter.
//
//   channel   direction  handshake                  payload
//   req       in         req_valid / req_ready      req_in_byte
//   rsp       out        rsp_valid / rsp_ready      rsp_out_byte, rsp_last
//   csr       in         csr_we                     csr_index, csr_wdata
//
// A control sequencer runs one step per cycle, unless a step waits for an input byte
// or for output room, and takes one input byte at a time. A line number prefix adds
// max(6, digits) + 1 bytes: the space-padded number and a tab.
// Reset is synchronous: line count 1, at line start, configuration and output valid cleared.
// An output stall freezes the sequencer at its next emitting step only.

`include "text_line_number_and_caret_filter_top_assert.svh"

module text_line_number_and_caret_filter_top
   import tlncf_pkg::*;
#(
   parameter int LINE_DIGITS = 10
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_in_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   ctrl_type   ctrl;
   status_type status;
   logic [7:0] emit_byte;
   logic       out_free;
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = ctrl.word.take;

   tlncf_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .req_valid (req_valid),
      .out_free  (out_free),
      .ctrl      (ctrl)
   );

   tlncf_datapath #(
      .LINE_DIGITS (LINE_DIGITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .req_in_byte (req_in_byte),
      .cfg         (cfg_ff),
      .status      (status),
      .emit_byte   (emit_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_NUMBER_MODE:   cfg_ff.number_mode   <= csr_wdata[1:0];
            CSR_SQUEEZE_BLANK: cfg_ff.squeeze_blank <= csr_wdata[0];
            CSR_END_MARK:      cfg_ff.end_mark      <= csr_wdata[0];
            CSR_TAB_CARET:     cfg_ff.tab_caret     <= csr_wdata[0];
            CSR_CTL_CARET:     cfg_ff.ctl_caret     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The output register frees up in the same cycle that its transfer completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.exec && ctrl.word.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec && ctrl.word.emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= ctrl.word.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   `TLNCF_ASSERT_IMP(a_emit_into_free_slot, ctrl.exec && ctrl.word.emit, !rsp_valid_ff || rsp_ready, "byte emitted over a waiting transfer")

endmodule
